// ----- hdl/tangent_orthonormalize_handedness_unit_defines.svh -----
// Assertion macros for the tangent orthonormalisation unit.
// No dependencies; taken in by the checker file.
`ifndef TANGENT_ORTHONORMALIZE_HANDEDNESS_UNIT_DEFINES_SVH
`define TANGENT_ORTHONORMALIZE_HANDEDNESS_UNIT_DEFINES_SVH

// same-cycle implication; pass 1'b0 as dis to keep the check live in reset
`define TOHU_ASSERT_IMPL(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TOHU_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/tohu_pkg.sv -----
// Shared constants and flag type for the tangent orthonormalisation unit.
// No dependencies.
package tohu_pkg;

  localparam int NORM_TOP  = 30;  // normalised magnitudes lie in [2^30, 2^31)
  localparam int MAG_W     = 31;
  localparam int SQ_W      = 64;
  localparam int LEN_W     = 32;
  localparam int D_LIM_EXP = 31;
  localparam int C_LIM_EXP = 30;
  localparam int D_W       = 33;
  localparam int C_W       = 32;

  typedef struct packed {
    logic [2:0] neg;
    logic       handed_neg;
    logic       degen;
  } tohu_flags_t;

endpackage

// ----- hdl/tohu_front.sv -----
// Front pipeline: dot and cross products, projection of the tangent, handedness sign.
// Depends on tohu_pkg.
module tohu_front
  import tohu_pkg::*;
#(
  parameter int W  = 16,
  parameter int F  = 14,
  parameter int PW = W + D_W - F + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [W-1:0]  n_i [3],
  input  logic signed [W-1:0]  t_i [3],
  input  logic signed [W-1:0]  b_i [3],
  output logic                 out_valid,
  output logic signed [PW-1:0] p_o [3],
  output logic                 handed_neg_o
);

  localparam int PRW  = 2 * W - F;
  localparam int SW   = PRW + 2;
  localparam int DW_E = ((SW > D_W) ? SW : D_W) + 1;
  localparam int XW   = PRW + 1;
  localparam int CW_E = ((XW > C_W) ? XW : C_W) + 1;
  localparam int NDW  = W + D_W;
  localparam int CBW  = C_W + W;
  localparam int DETW = CBW + 2;
  localparam longint D_LIM = 64'sd1 <<< D_LIM_EXP;
  localparam longint C_LIM = 64'sd1 <<< C_LIM_EXP;

  function automatic logic signed [PRW-1:0] mulf(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
    logic signed [2*W-1:0] pr;
    pr = a * b;
    return PRW'(pr >>> F);
  endfunction

  // stage 1
  logic                  v1_r;
  logic signed [PRW-1:0] dp1_r [3];
  logic signed [PRW-1:0] cp1_r [6];
  logic signed [W-1:0]   n1_r [3], t1_r [3], b1_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) dp1_r[i] <= mulf(n_i[i], t_i[i]);
      cp1_r[0] <= mulf(n_i[1], t_i[2]);
      cp1_r[1] <= mulf(n_i[2], t_i[1]);
      cp1_r[2] <= mulf(n_i[2], t_i[0]);
      cp1_r[3] <= mulf(n_i[0], t_i[2]);
      cp1_r[4] <= mulf(n_i[0], t_i[1]);
      cp1_r[5] <= mulf(n_i[1], t_i[0]);
      n1_r <= n_i;
      t1_r <= t_i;
      b1_r <= b_i;
    end
  end

  // stage 2
  logic signed [DW_E-1:0] dsum;
  logic signed [D_W-1:0]  d_nxt;
  logic signed [CW_E-1:0] xd [3];
  logic signed [C_W-1:0]  c_nxt [3];

  always_comb begin
    dsum = DW_E'(dp1_r[0]) + DW_E'(dp1_r[1]) + DW_E'(dp1_r[2]);
    if (dsum > DW_E'(D_LIM)) d_nxt = D_W'(D_LIM);
    else if (dsum < DW_E'(-D_LIM)) d_nxt = D_W'(-D_LIM);
    else d_nxt = D_W'(dsum);
    for (int i = 0; i < 3; i++) begin
      xd[i] = CW_E'(cp1_r[2*i]) - CW_E'(cp1_r[2*i+1]);
      if (xd[i] > CW_E'(C_LIM)) c_nxt[i] = C_W'(C_LIM);
      else if (xd[i] < CW_E'(-C_LIM)) c_nxt[i] = C_W'(-C_LIM);
      else c_nxt[i] = C_W'(xd[i]);
    end
  end

  logic                  v2_r;
  logic signed [D_W-1:0] d2_r;
  logic signed [C_W-1:0] c2_r [3];
  logic signed [W-1:0]   n2_r [3], t2_r [3], b2_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_r <= d_nxt;
      c2_r <= c_nxt;
      n2_r <= n1_r;
      t2_r <= t1_r;
      b2_r <= b1_r;
    end
  end

  // stage 3
  logic                  v3_r;
  logic signed [NDW-1:0] nd3_r [3];
  logic signed [CBW-1:0] cb3_r [3];
  logic signed [W-1:0]   t3_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nd3_r[i] <= n2_r[i] * d2_r;
        cb3_r[i] <= c2_r[i] * b2_r[i];
      end
      t3_r <= t2_r;
    end
  end

  // stage 4
  logic signed [DETW-1:0] det;
  logic signed [PW-1:0]   p_nxt [3];

  always_comb begin
    det = DETW'(cb3_r[0]) + DETW'(cb3_r[1]) + DETW'(cb3_r[2]);
    for (int i = 0; i < 3; i++) p_nxt[i] = PW'(t3_r[i]) - PW'(nd3_r[i] >>> F);
  end

  logic                 v4_r;
  logic signed [PW-1:0] p4_r [3];
  logic                 h4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_r <= p_nxt;
      h4_r <= det[DETW-1];
    end
  end

  assign out_valid    = v4_r;
  assign p_o          = p4_r;
  assign handed_neg_o = h4_r;

endmodule

// ----- hdl/tohu_norm.sv -----
// Magnitude normalisation and sum of squares of the projected tangent.
// Depends on tohu_pkg.
module tohu_norm
  import tohu_pkg::*;
#(
  parameter int PW = 36
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [PW-1:0] p_i [3],
  input  logic                 handed_neg_i,
  output logic                 out_valid,
  output logic [MAG_W-1:0]     m_o [3],
  output logic [SQ_W-1:0]      sumsq_o,
  output tohu_flags_t          flags_o
);

  localparam int G     = (PW + 7) / 8;
  localparam int GI_W  = (G > 1) ? $clog2(G) : 1;
  localparam int POS_W = GI_W + 3;
  localparam int GPW   = G * 8;
  localparam int SHW   = PW + NORM_TOP;

  // stage 5: magnitudes, coarse leading byte
  logic [PW-1:0]   mag [3];
  logic [GPW-1:0]  orx;
  logic [GI_W-1:0] gidx;
  tohu_flags_t     f5_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) mag[i] = p_i[i][PW-1] ? PW'(-p_i[i]) : PW'(p_i[i]);
    orx  = GPW'(mag[0] | mag[1] | mag[2]);
    gidx = '0;
    for (int g = 0; g < G; g++) begin
      if (orx[g*8 +: 8] != 8'd0) gidx = GI_W'(g);
    end
    f5_nxt.neg        = {p_i[2][PW-1], p_i[1][PW-1], p_i[0][PW-1]};
    f5_nxt.handed_neg = handed_neg_i;
    f5_nxt.degen      = (orx == '0);
  end

  logic            v5_r;
  logic [PW-1:0]   m5_r [3];
  logic [GPW-1:0]  or5_r;
  logic [GI_W-1:0] g5_r;
  tohu_flags_t     f5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m5_r  <= mag;
      or5_r <= orx;
      g5_r  <= gidx;
      f5_r  <= f5_nxt;
    end
  end

  // stage 6: fine bit position within the leading byte
  logic [7:0] lead;
  logic [2:0] fine;

  always_comb begin
    lead = or5_r[g5_r*8 +: 8];
    fine = '0;
    for (int k = 0; k < 8; k++) begin
      if (lead[k]) fine = 3'(k);
    end
  end

  logic             v6_r;
  logic [PW-1:0]    m6_r [3];
  logic [POS_W-1:0] pos6_r;
  tohu_flags_t      f6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m6_r   <= m5_r;
      pos6_r <= {g5_r, fine};
      f6_r   <= f5_r;
    end
  end

  // stage 7: byte shift of m << 30
  logic           v7_r;
  logic [SHW-1:0] x7_r [3];
  logic [2:0]     fine7_r;
  tohu_flags_t    f7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (en) v7_r <= v6_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        x7_r[i] <= {m6_r[i], NORM_TOP'(0)} >> {pos6_r[POS_W-1:3], 3'b000};
      fine7_r <= pos6_r[2:0];
      f7_r    <= f6_r;
    end
  end

  // stage 8: bit shift
  logic             v8_r;
  logic [MAG_W-1:0] m8_r [3];
  tohu_flags_t      f8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else if (en) v8_r <= v7_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) m8_r[i] <= MAG_W'(x7_r[i] >> fine7_r);
      f8_r <= f7_r;
    end
  end

  // stage 9: squares
  logic               v9_r;
  logic [MAG_W-1:0]   m9_r [3];
  logic [2*MAG_W-1:0] sq9_r [3];
  tohu_flags_t        f9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v9_r <= 1'b0;
    else if (en) v9_r <= v8_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq9_r[i] <= m8_r[i] * m8_r[i];
      m9_r <= m8_r;
      f9_r <= f8_r;
    end
  end

  // stage 10: sum
  logic             v10_r;
  logic [MAG_W-1:0] m10_r [3];
  logic [SQ_W-1:0]  sum10_r;
  tohu_flags_t      f10_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v10_r <= 1'b0;
    else if (en) v10_r <= v9_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum10_r <= SQ_W'(sq9_r[0]) + SQ_W'(sq9_r[1]) + SQ_W'(sq9_r[2]);
      m10_r   <= m9_r;
      f10_r   <= f9_r;
    end
  end

  assign out_valid = v10_r;
  assign m_o       = m10_r;
  assign sumsq_o   = sum10_r;
  assign flags_o   = f10_r;

endmodule

// ----- hdl/tohu_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// Depends on tohu_pkg.
module tohu_sqrt
  import tohu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [SQ_W-1:0]  sumsq_i,
  input  logic [MAG_W-1:0] m_i [3],
  input  tohu_flags_t      flags_i,
  output logic             out_valid,
  output logic [LEN_W-1:0] len_o,
  output logic [MAG_W-1:0] m_o [3],
  output tohu_flags_t      flags_o
);

  localparam int STEPS = LEN_W;

  logic             v_r [STEPS];
  logic [SQ_W-1:0]  x_r [STEPS];
  logic [SQ_W-1:0]  r_r [STEPS];
  logic [MAG_W-1:0] m_r [STEPS][3];
  tohu_flags_t      f_r [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * s);

    logic             v_in;
    logic [SQ_W-1:0]  x_in, r_in, trial;
    logic [MAG_W-1:0] m_in [3];
    tohu_flags_t      f_in;

    if (s == 0) begin : g_first
      assign v_in = in_valid;
      assign x_in = sumsq_i;
      assign r_in = '0;
      assign m_in = m_i;
      assign f_in = flags_i;
    end else begin : g_rest
      assign v_in = v_r[s-1];
      assign x_in = x_r[s-1];
      assign r_in = r_r[s-1];
      assign m_in = m_r[s-1];
      assign f_in = f_r[s-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[s] <= 1'b0;
      else if (en) v_r[s] <= v_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (x_in >= trial) begin
          x_r[s] <= x_in - trial;
          r_r[s] <= (r_in >> 1) + BIT;
        end else begin
          x_r[s] <= x_in;
          r_r[s] <= r_in >> 1;
        end
        m_r[s] <= m_in;
        f_r[s] <= f_in;
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign len_o     = LEN_W'(r_r[STEPS-1]);
  assign m_o       = m_r[STEPS-1];
  assign flags_o   = f_r[STEPS-1];

endmodule

// ----- hdl/tohu_div.sv -----
// Pipelined rounded division of three magnitudes by the length: a rounding stage, then one quotient bit per stage.
// Depends on tohu_pkg.
module tohu_div
  import tohu_pkg::*;
#(
  parameter int F = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [LEN_W-1:0] len_i,
  input  logic [MAG_W-1:0] m_i [3],
  input  tohu_flags_t      flags_i,
  output logic             out_valid,
  output logic [F:0]       q_o [3],
  output tohu_flags_t      flags_o
);

  localparam int NUM_W = LEN_W + F;
  localparam int Q_W   = F + 1;
  localparam int NS    = F + 2;

  logic             v_r   [NS];
  logic [NUM_W-1:0] rem_r [NS][3];
  logic [Q_W-1:0]   q_r   [NS][3];
  logic [LEN_W-1:0] len_r [NS];
  tohu_flags_t      f_r   [NS];

  // numerator with half the divisor added for rounding
  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (en) v_r[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rem_r[0][i] <= (NUM_W'(m_i[i]) << F) + NUM_W'(len_i >> 1);
        q_r[0][i]   <= '0;
      end
      len_r[0] <= len_i;
      f_r[0]   <= flags_i;
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_step
    localparam int K = NS - 1 - s;

    logic [NUM_W-1:0] dvs;
    assign dvs = NUM_W'(len_r[s-1]) << K;

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[s] <= 1'b0;
      else if (en) v_r[s] <= v_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (rem_r[s-1][i] >= dvs) begin
            rem_r[s][i] <= rem_r[s-1][i] - dvs;
            q_r[s][i]   <= q_r[s-1][i] | (Q_W'(1) << K);
          end else begin
            rem_r[s][i] <= rem_r[s-1][i];
            q_r[s][i]   <= q_r[s-1][i];
          end
        end
        len_r[s] <= len_r[s-1];
        f_r[s]   <= f_r[s-1];
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign q_o       = q_r[NS-1];
  assign flags_o   = f_r[NS-1];

endmodule

// ----- hdl/tangent_orthonormalize_handedness_unit.sv -----
// Top level of the tangent orthonormalisation unit: input unpacking, output saturation.
// Depends on tohu_pkg, tohu_front, tohu_norm, tohu_sqrt, tohu_div.
//
//  channel | dir | tdata (low bit up)                              | tuser
//  in_     | in  | normal x,y,z, tangent x,y,z, bitangent x,y,z     | -
//  out_    | out | unit tangent x,y,z, handed_negative             | degenerate
//
// One word accepted every cycle unless a held output word stalls; the pipeline includes
// the 32-stage square root and the FRAC_BITS + 2 stage divider.
// rst_n clears all valid bits; payload registers are not reset.
// A held output word stalls every stage at once; in_tready follows the output slot.
module tangent_orthonormalize_handedness_unit
  import tohu_pkg::*;
#(
  parameter int COMP_WIDTH = 16,
  parameter int FRAC_BITS  = 14,
  localparam int IN_DW     = ((9 * COMP_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW    = ((3 * COMP_WIDTH + 1 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // normal_x/y/z, tangent_x/y/z, bitangent_x/y/z
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // unit_tangent_x/y/z, handed_negative
  output logic [0:0]        out_tuser   // degenerate
);

  localparam int W     = COMP_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int PW    = W + D_W - F + 1;
  localparam int SAT_W = ((F + 2 > W) ? F + 2 : W) + 1;
  localparam longint HI = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam longint LO = -HI - 64'sd1;

  logic en;
  logic out_valid_r;
  logic [OUT_DW-1:0] out_data_r;
  logic out_degen_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  logic signed [W-1:0] n [3], t [3], b [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n[i] = $signed(in_tdata[i*W +: W]);
      t[i] = $signed(in_tdata[(3+i)*W +: W]);
      b[i] = $signed(in_tdata[(6+i)*W +: W]);
    end
  end

  logic                 fr_valid;
  logic signed [PW-1:0] fr_p [3];
  logic                 fr_handed;

  tohu_front #(.W(W), .F(F), .PW(PW)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_tvalid),
    .n_i          (n),
    .t_i          (t),
    .b_i          (b),
    .out_valid    (fr_valid),
    .p_o          (fr_p),
    .handed_neg_o (fr_handed)
  );

  logic             nm_valid;
  logic [MAG_W-1:0] nm_m [3];
  logic [SQ_W-1:0]  nm_sumsq;
  tohu_flags_t      nm_flags;

  tohu_norm #(.PW(PW)) u_norm (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (fr_valid),
    .p_i          (fr_p),
    .handed_neg_i (fr_handed),
    .out_valid    (nm_valid),
    .m_o          (nm_m),
    .sumsq_o      (nm_sumsq),
    .flags_o      (nm_flags)
  );

  logic             sq_valid;
  logic [LEN_W-1:0] sq_len;
  logic [MAG_W-1:0] sq_m [3];
  tohu_flags_t      sq_flags;

  tohu_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (nm_valid),
    .sumsq_i   (nm_sumsq),
    .m_i       (nm_m),
    .flags_i   (nm_flags),
    .out_valid (sq_valid),
    .len_o     (sq_len),
    .m_o       (sq_m),
    .flags_o   (sq_flags)
  );

  logic        dv_valid;
  logic [F:0]  dv_q [3];
  tohu_flags_t dv_flags;

  tohu_div #(.F(F)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .len_i     (sq_len),
    .m_i       (sq_m),
    .flags_i   (sq_flags),
    .out_valid (dv_valid),
    .q_o       (dv_q),
    .flags_o   (dv_flags)
  );

  // sign, saturation, degenerate override
  logic signed [SAT_W-1:0] sv [3];
  logic signed [W-1:0]     comp [3];
  logic [OUT_DW-1:0]       data_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sv[i] = signed'(SAT_W'(dv_q[i]));
      if (dv_flags.neg[i]) sv[i] = -sv[i];
      if (dv_flags.degen) comp[i] = '0;
      else if (sv[i] > SAT_W'(HI)) comp[i] = W'(HI);
      else if (sv[i] < SAT_W'(LO)) comp[i] = W'(LO);
      else comp[i] = W'(sv[i]);
    end
    data_nxt = OUT_DW'({dv_flags.handed_neg, comp[2], comp[1], comp[0]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= dv_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r  <= data_nxt;
      out_degen_r <= dv_flags.degen;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_degen_r;

endmodule

// ----- hdl/tohu_checker.sv -----
// Port-level checks for the tangent orthonormalisation unit, bound to the top level.
// Depends on tangent_orthonormalize_handedness_unit_defines.svh.
`include "tangent_orthonormalize_handedness_unit_defines.svh"

module tohu_checker #(
  parameter int COMP_WIDTH = 16,
  localparam int OUT_DW    = ((3 * COMP_WIDTH + 1 + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic [0:0]        out_tuser
);

  `TOHU_ASSERT_NEXT(a_out_hold, clk, !rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "output word changed while held")

  `TOHU_ASSERT_IMPL(a_ready_free, clk, !rst_n, !out_tvalid || out_tready, in_tready,
    "input stalled with output slot free")

  `TOHU_ASSERT_IMPL(a_degen_zero, clk, !rst_n, out_tvalid && out_tuser[0],
    out_tdata[3*COMP_WIDTH-1:0] == '0, "degenerate word with nonzero tangent")

  `TOHU_ASSERT_NEXT(a_reset_idle, clk, 1'b0, !rst_n, !out_tvalid,
    "output valid after reset")

endmodule

bind tangent_orthonormalize_handedness_unit tohu_checker #(.COMP_WIDTH(COMP_WIDTH)) u_tohu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- verif/testbench.sv -----
// Testbench for tangent_orthonormalize_handedness_unit: a directed table then random vertices.
// Depends on the unit's RTL. Each output word is checked against its table entry or a self-contained predictor.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [15:0] ux;
    logic [15:0] uy;
    logic [15:0] uz;
    logic        hn;
    logic        dg;
  } tangent_res_t;

  typedef struct {
    bit           typed;
    tangent_res_t res;
  } typed_exp_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [55:0]  out_tdata;
  logic [0:0]   out_tuser;

  tangent_res_t tangent_exp_q[$];
  typed_exp_t   typed_q[$];
  logic [143:0] row_data_q[$];
  typed_exp_t   row_exp_q[$];
  int           n_errors = 0;
  int           n_accepted = 0;

  tangent_orthonormalize_handedness_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint mulq(longint a, longint b);
    return (a * b) >>> 14;
  endfunction

  function automatic longint clampq(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  function automatic tangent_res_t orthonormalize(logic [143:0] d);
    longint n[3], t[3], b[3], p[3], c[3];
    longint dt, det, v;
    longint unsigned m[3], mx, sumsq, len, q;
    tangent_res_t r;
    for (int i = 0; i < 3; i++) begin
      n[i] = longint'($signed(d[16*i +: 16]));
      t[i] = longint'($signed(d[16*(3+i) +: 16]));
      b[i] = longint'($signed(d[16*(6+i) +: 16]));
    end
    dt = clampq(mulq(n[0], t[0]) + mulq(n[1], t[1]) + mulq(n[2], t[2]), 64'sd1 << 31);
    for (int i = 0; i < 3; i++) p[i] = t[i] - mulq(n[i], dt);
    c[0] = clampq(mulq(n[1], t[2]) - mulq(n[2], t[1]), 64'sd1 << 30);
    c[1] = clampq(mulq(n[2], t[0]) - mulq(n[0], t[2]), 64'sd1 << 30);
    c[2] = clampq(mulq(n[0], t[1]) - mulq(n[1], t[0]), 64'sd1 << 30);
    det = c[0] * b[0] + c[1] * b[1] + c[2] * b[2];
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (p[i] < 0) ? longint'(-p[i]) : longint'(p[i]);
      if (m[i] > mx) mx = m[i];
    end
    r = '0;
    r.dg = (mx == 0);
    r.hn = (det < 0);
    if (mx != 0) begin
      while (mx >= (64'd1 << 31)) begin
        mx >>= 1;
        for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      while (mx < (64'd1 << 30)) begin
        mx <<= 1;
        for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      sumsq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      len = floor_sqrt(sumsq);
      for (int i = 0; i < 3; i++) begin
        q = ((m[i] << 14) + (len >> 1)) / len;
        v = longint'(q);
        if (p[i] < 0) v = -v;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        case (i)
          0: r.ux = v[15:0];
          1: r.uy = v[15:0];
          default: r.uz = v[15:0];
        endcase
      end
    end
    return r;
  endfunction

  function automatic logic [143:0] pack_vertex(int c0, int c1, int c2, int c3, int c4,
                                               int c5, int c6, int c7, int c8);
    logic [143:0] d;
    int cs[9];
    cs = '{c0, c1, c2, c3, c4, c5, c6, c7, c8};
    for (int i = 0; i < 9; i++) d[16*i +: 16] = cs[i][15:0];
    return d;
  endfunction

  task automatic add_row(logic [143:0] d, bit typed, tangent_res_t r);
    typed_exp_t e;
    e.typed = typed;
    e.res = r;
    row_data_q.insert(row_data_q.size(), d);
    row_exp_q.insert(row_exp_q.size(), e);
  endtask

  task automatic report_mismatch(string field, int idx, longint got, longint want);
    $display("mismatch word %0d %s: got %0d want %0d", idx, field, got, want);
    n_errors++;
  endtask

  task automatic send_vertex(logic [143:0] d, typed_exp_t e);
    typed_q.insert(typed_q.size(), e);
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic int rand_comp(int kind);
    int pick;
    case (kind)
      0: return $urandom_range(0, 65535) - 32768;
      1: return $urandom_range(0, 8) - 4;
      default: begin
        pick = $urandom_range(0, 4);
        case (pick)
          0: return -32768;
          1: return 32767;
          2: return 16384;
          3: return -16384;
          default: return 0;
        endcase
      end
    endcase
  endfunction

  // expectation from the table or the predictor, taken on input acceptance
  always @(posedge clk) begin
    typed_exp_t e;
    if (rst_n && in_tvalid && in_tready) begin
      e = typed_q.pop_front();
      tangent_exp_q.insert(tangent_exp_q.size(), e.typed ? e.res : orthonormalize(in_tdata));
      n_accepted++;
    end
  end

  // output checker
  always @(posedge clk) begin
    tangent_res_t w;
    int idx;
    if (rst_n && out_tvalid && out_tready) begin
      idx = n_accepted - tangent_exp_q.size();
      if (tangent_exp_q.size() == 0) begin
        report_mismatch("unexpected", idx, 1, 0);
      end else begin
        w = tangent_exp_q.pop_front();
        if (out_tdata[15:0] !== w.ux)
          report_mismatch("unit_x", idx, $signed(out_tdata[15:0]), $signed(w.ux));
        if (out_tdata[31:16] !== w.uy)
          report_mismatch("unit_y", idx, $signed(out_tdata[31:16]), $signed(w.uy));
        if (out_tdata[47:32] !== w.uz)
          report_mismatch("unit_z", idx, $signed(out_tdata[47:32]), $signed(w.uz));
        if (out_tdata[48] !== w.hn) report_mismatch("handed_neg", idx, out_tdata[48], w.hn);
        if (out_tuser[0] !== w.dg) report_mismatch("degenerate", idx, out_tuser[0], w.dg);
      end
    end
  end

  // receiver: stall pattern with one long hold-off
  initial begin
    int mode;
    int held;
    out_tready = 1'b0;
    held = 0;
    mode = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && n_accepted >= 150) begin
        held = 1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
      @(posedge clk);
    end
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    typed_exp_t e;
    tangent_res_t z;
    int kind, burst, nk, nt, nb;
    int cs[9];
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    z = '0;

    add_row(pack_vertex(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{16'd0, 16'd0, 16'd0, 1'b0, 1'b1});
    add_row(pack_vertex(0, 0, 0, 16384, 0, 0, 0, 0, 0), 1,
            '{16'd16384, 16'd0, 16'd0, 1'b0, 1'b0});
    add_row(pack_vertex(0, 0, 0, -16384, 0, 0, 0, 0, 0), 1,
            '{16'hC000, 16'd0, 16'd0, 1'b0, 1'b0});
    add_row(pack_vertex(0, 0, 0, 32767, 0, 0, 0, 0, 0), 1,
            '{16'd16384, 16'd0, 16'd0, 1'b0, 1'b0});
    add_row(pack_vertex(16384, 0, 0, 16384, 0, 0, 0, 0, 0), 1,
            '{16'd0, 16'd0, 16'd0, 1'b0, 1'b1});
    add_row(pack_vertex(0, 0, 16384, 16384, 0, 0, 0, -16384, 0), 1,
            '{16'd16384, 16'd0, 16'd0, 1'b1, 1'b0});
    add_row(pack_vertex(0, 0, 16384, 16384, 0, 0, 0, 16384, 0), 1,
            '{16'd16384, 16'd0, 16'd0, 1'b0, 1'b0});
    add_row(pack_vertex(0, 0, 16384, 0, 0, 16384, 0, 0, 0), 1,
            '{16'd0, 16'd0, 16'd0, 1'b0, 1'b1});
    add_row(pack_vertex(-32768, -32768, -32768, -32768, -32768, -32768,
                        -32768, -32768, -32768), 0, z);
    add_row(pack_vertex(32767, 32767, 32767, 32767, 32767, 32767,
                        32767, 32767, 32767), 0, z);
    add_row(pack_vertex(32767, -32768, 0, -32768, 32767, 1, 32767, -32768, 32767), 0, z);
    add_row(pack_vertex(0, 16384, 0, 1, 0, 0, 0, 0, 1), 0, z);
    add_row(pack_vertex(0, 0, 0, 1, -1, 1, -1, 1, -1), 0, z);
    add_row(pack_vertex(11585, 11585, 0, 16384, 0, 0, 0, 0, -16384), 0, z);
    add_row(pack_vertex(-16384, 0, 0, 5, 16000, -7, 100, -200, 300), 0, z);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    while (row_data_q.size() != 0) begin
      send_vertex(row_data_q.pop_front(), row_exp_q.pop_front());
      if ($urandom_range(0, 2) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end

    e.typed = 0;
    e.res = z;
    nk = 0;
    while (nk < 500) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst && nk < 500; j++) begin
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
          for (int i = 0; i < 9; i++) cs[i] = rand_comp(0);
        end else if (kind < 7) begin
          // near-unit normal along a random axis
          for (int i = 0; i < 9; i++) cs[i] = rand_comp(0);
          nt = $urandom_range(0, 2);
          for (int i = 0; i < 3; i++)
            cs[i] = (i == nt) ? (($urandom_range(0, 1) != 0) ? 16384 : -16384)
                              : rand_comp(1);
        end else if (kind == 7) begin
          for (int i = 0; i < 9; i++) cs[i] = rand_comp(1);
        end else if (kind == 8) begin
          // tangent along the unit normal: projection vanishes
          nb = $urandom_range(0, 2);
          for (int i = 0; i < 3; i++) begin
            cs[i] = (i == nb) ? 16384 : 0;
            cs[3+i] = (i == nb) ? ($urandom_range(0, 65535) - 32768) : 0;
            cs[6+i] = rand_comp(0);
          end
        end else begin
          for (int i = 0; i < 9; i++) cs[i] = rand_comp(2);
        end
        send_vertex(pack_vertex(cs[0], cs[1], cs[2], cs[3], cs[4], cs[5], cs[6], cs[7],
                                cs[8]), e);
        nk++;
      end
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;

    while (tangent_exp_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
